FILE: src/spm_pkg.sv
// Package for the sparse polynomial multiplier: sizes, item kinds,
// sequencer states and the structs passed between the modules.
// No dependencies.
`default_nettype none

package spm_pkg;

  // Term stores.
  localparam int MAX_TERMS_FIRST  = 8;
  localparam int MAX_TERMS_SECOND = 8;
  localparam int TERM_DEPTH       = 8;
  localparam int TIDX_W           = $clog2(TERM_DEPTH);
  localparam int TCNT_W           = $clog2(TERM_DEPTH + 1);

  // Field widths.
  localparam int COEF_W  = 16;
  localparam int EXP_W   = 8;
  localparam int MUL_W   = 2 * COEF_W;
  localparam int PCOEF_W = 38;
  localparam int PEXP_W  = 9;

  // Product memory.
  localparam int PROD_DEPTH = MAX_TERMS_FIRST * MAX_TERMS_SECOND;
  localparam int PADDR_W    = $clog2(PROD_DEPTH);
  localparam int PCNT_W     = $clog2(PROD_DEPTH + 1);

  // Item kinds on the input channel.
  typedef enum logic [1:0] {
    KIND_FIRST  = 2'd0,
    KIND_SECOND = 2'd1,
    KIND_MUL    = 2'd2,
    KIND_IGNORE = 2'd3
  } kind_t;

  // Sequencer states, one-hot.
  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_FETCH = 8'b0000_0010,
    ST_MUL   = 8'b0000_0100,
    ST_SRCH  = 8'b0000_1000,
    ST_CMP   = 8'b0001_0000,
    ST_ERD   = 8'b0010_0000,
    ST_ELD   = 8'b0100_0000,
    ST_EWAIT = 8'b1000_0000
  } state_t;

  // Control of one term store.
  typedef struct packed {
    logic                     wr;
    logic                     clr;
    logic signed [COEF_W-1:0] coef;
    logic [EXP_W-1:0]         texp;
  } term_ctl_t;

  // One entry of the product memory.
  typedef struct packed {
    logic [PEXP_W-1:0]         pexp;
    logic signed [PCOEF_W-1:0] pcoef;
  } prod_word_t;

endpackage : spm_pkg

`default_nettype wire

FILE: src/sparse_polynomial_multiply.sv
// Sparse polynomial multiplier, top level: handshakes, sequencer, multiply
// and merge datapath. Depends on spm_pkg, spm_term_store, spm_prod_mem.
`default_nettype none

// A load item (kind 0 or 1) is taken while the block is idle and adds a term to
// the first or second store; a store holds up to eight terms and drops the rest.
// A multiply item (kind 2) makes the block busy until its last result term is
// taken. For each of the F*S term pairs it fetches and multiplies the terms
// (states ST_FETCH and ST_MUL), then scans the product memory entry by entry
// (ST_SRCH reads, ST_CMP compares) until it finds the same exponent (and adds
// the coefficients) or reaches the end (and appends a new entry). Each result
// term then goes through ST_ERD, ST_ELD and ST_EWAIT, which waits for out_ready.
// Results come in the order their exponents first appear, the last one marked
// by out_last_term, and both stores are emptied afterward. A multiply item with
// an empty store gives no result and only empties the stores; kind 3 is
// ignored.
module sparse_polynomial_multiply (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire [1:0]                          in_kind,
  input  wire signed [spm_pkg::COEF_W-1:0]   in_term_coef,
  input  wire [spm_pkg::EXP_W-1:0]           in_term_exp,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic signed [spm_pkg::PCOEF_W-1:0] out_prod_coef,
  output logic [spm_pkg::PEXP_W-1:0]         out_prod_exp,
  output logic                               out_last_term
);
  import spm_pkg::*;

  state_t              state_r, state_nxt;
  logic [TIDX_W-1:0]   i_r, i_nxt;
  logic [TIDX_W-1:0]   j_r, j_nxt;
  logic [PCNT_W-1:0]   k_r, k_nxt;
  logic [PCNT_W-1:0]   pcnt_r, pcnt_nxt;
  logic signed [MUL_W-1:0] prod_r;
  logic [PEXP_W-1:0]   esum_r;
  logic                out_valid_r, out_valid_nxt;
  logic                last_r;

  term_ctl_t           ctl_a, ctl_b;
  logic                clr;
  logic signed [COEF_W-1:0] a_coef, b_coef;
  logic [EXP_W-1:0]    a_exp, b_exp;
  logic [TCNT_W-1:0]   fcnt, scnt;

  logic                mem_we;
  logic [PADDR_W-1:0]  mem_waddr;
  prod_word_t          mem_wdata, mem_rdata;

  logic                in_acc, out_acc;
  kind_t               kind;
  logic                match, j_end, i_end;
  logic                pair_done;
  logic signed [PCOEF_W-1:0] prod_ext;

  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid_r && out_ready;
  assign kind     = kind_t'(in_kind);
  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_last_term = last_r;

  // Term store controls.
  always_comb begin
    ctl_a.wr   = in_acc && (kind == KIND_FIRST);
    ctl_a.clr  = clr;
    ctl_a.coef = in_term_coef;
    ctl_a.texp = in_term_exp;
    ctl_b.wr   = in_acc && (kind == KIND_SECOND);
    ctl_b.clr  = clr;
    ctl_b.coef = in_term_coef;
    ctl_b.texp = in_term_exp;
  end

  spm_term_store u_first (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl_a),
    .cap     (TCNT_W'(MAX_TERMS_FIRST)),
    .rd_idx  (i_r),
    .rd_coef (a_coef),
    .rd_exp  (a_exp),
    .count   (fcnt)
  );

  spm_term_store u_second (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl_b),
    .cap     (TCNT_W'(MAX_TERMS_SECOND)),
    .rd_idx  (j_r),
    .rd_coef (b_coef),
    .rd_exp  (b_exp),
    .count   (scnt)
  );

  spm_prod_mem u_prod (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (k_r[PADDR_W-1:0]),
    .rdata (mem_rdata)
  );

  // Multiplier and exponent adder, registered.
  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      prod_r <= MUL_W'(a_coef) * MUL_W'(b_coef);
      esum_r <= PEXP_W'(a_exp) + PEXP_W'(b_exp);
    end
  end

  // Merge datapath: one compare and one wide add into the scanned entry.
  assign prod_ext = {{(PCOEF_W - MUL_W){prod_r[MUL_W-1]}}, prod_r};
  assign match    = (mem_rdata.pexp == esum_r);
  assign j_end    = ({1'b0, j_r} + TCNT_W'(1)) == scnt;
  assign i_end    = ({1'b0, i_r} + TCNT_W'(1)) == fcnt;

  // A pair is done when it is appended past the end or merged into an entry.
  assign pair_done = (state_r == ST_SRCH && k_r == pcnt_r) ||
                     (state_r == ST_CMP && match);

  always_comb begin
    mem_we          = 1'b0;
    mem_waddr       = k_r[PADDR_W-1:0];
    mem_wdata.pexp  = esum_r;
    mem_wdata.pcoef = mem_rdata.pcoef + prod_ext;
    if (state_r == ST_SRCH && k_r == pcnt_r) begin
      mem_we          = 1'b1;
      mem_waddr       = pcnt_r[PADDR_W-1:0];
      mem_wdata.pcoef = prod_ext;
    end else if (state_r == ST_CMP && match) begin
      mem_we = 1'b1;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    pcnt_nxt      = pcnt_r;
    out_valid_nxt = out_valid_r;
    clr           = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && kind == KIND_MUL) begin
          i_nxt    = '0;
          j_nxt    = '0;
          pcnt_nxt = '0;
          if (fcnt == '0 || scnt == '0) begin
            clr = 1'b1;
          end else begin
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_FETCH: state_nxt = ST_MUL;
      ST_MUL: begin
        k_nxt     = '0;
        state_nxt = ST_SRCH;
      end
      ST_SRCH: begin
        // Past the last entry the product is appended and the pair is done.
        if (k_r == pcnt_r) begin
          pcnt_nxt = pcnt_r + PCNT_W'(1);
        end else begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (!match) begin
          k_nxt     = k_r + PCNT_W'(1);
          state_nxt = ST_SRCH;
        end
      end
      ST_ERD: state_nxt = ST_ELD;
      ST_ELD: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_EWAIT;
      end
      ST_EWAIT: begin
        if (out_acc) begin
          out_valid_nxt = 1'b0;
          if (last_r) begin
            clr       = 1'b1;
            pcnt_nxt  = '0;
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + PCNT_W'(1);
            state_nxt = ST_ERD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // A finished pair moves on to the next pair, or to emitting after the last.
    if (pair_done) begin
      state_nxt = ST_FETCH;
      if (j_end) begin
        j_nxt = '0;
        if (i_end) begin
          k_nxt     = '0;
          state_nxt = ST_ERD;
        end else begin
          i_nxt = i_r + TIDX_W'(1);
        end
      end else begin
        j_nxt = j_r + TIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      pcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      pcnt_r      <= pcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output register, loaded in ST_ELD from the registered memory read of the address given in ST_ERD.
  always_ff @(posedge clk) begin
    if (state_r == ST_ELD) begin
      out_prod_coef <= mem_rdata.pcoef;
      out_prod_exp  <= mem_rdata.pexp;
      last_r        <= (k_r + PCNT_W'(1)) == pcnt_r;
    end
  end

`ifndef SYNTHESIS
  // A result is offered only while the sequencer waits for it to be taken.
  a_out_in_ewait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == ST_EWAIT)
    else $error("result offered outside the emit wait state");

  // Input and result channels are never open together.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid_r))
    else $error("input ready while a result is pending");

  // The product memory never holds more entries than its depth, the largest number of term pairs.
  a_pcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r <= PCNT_W'(PROD_DEPTH))
    else $error("product count beyond memory depth");

  // Taking the last result empties both term stores.
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && last_r) |=> (fcnt == '0 && scnt == '0 && state_r == ST_IDLE))
    else $error("term stores not emptied after the last result");
`endif

endmodule : sparse_polynomial_multiply

`default_nettype wire

FILE: src/spm_term_store.sv
// Term store for one polynomial: coefficient and exponent arrays with a
// fill count and a registered read port. Depends on spm_pkg.
`default_nettype none

module spm_term_store (
  input  wire                              clk,
  input  wire                              rst_n,
  input  spm_pkg::term_ctl_t               ctl,
  input  wire [spm_pkg::TCNT_W-1:0]        cap,
  input  wire [spm_pkg::TIDX_W-1:0]        rd_idx,
  output logic signed [spm_pkg::COEF_W-1:0] rd_coef,
  output logic [spm_pkg::EXP_W-1:0]        rd_exp,
  output logic [spm_pkg::TCNT_W-1:0]       count
);
  import spm_pkg::*;

  logic signed [COEF_W-1:0] coefs [TERM_DEPTH];
  logic [EXP_W-1:0]         exps  [TERM_DEPTH];
  logic [TCNT_W-1:0]        count_r;
  logic                     wr_ok;

  // A term is dropped once the store holds cap terms.
  assign wr_ok = ctl.wr && (count_r < cap);
  assign count = count_r;

  // Fill count; a clear empties the store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.clr) begin
      count_r <= '0;
    end else if (wr_ok) begin
      count_r <= count_r + TCNT_W'(1);
    end
  end

  // Storage, written at the fill count.
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      coefs[count_r[TIDX_W-1:0]] <= ctl.coef;
      exps[count_r[TIDX_W-1:0]]  <= ctl.texp;
    end
  end

  // Registered read.
  always_ff @(posedge clk) begin
    rd_coef <= coefs[rd_idx];
    rd_exp  <= exps[rd_idx];
  end

endmodule : spm_term_store

`default_nettype wire

FILE: src/spm_prod_mem.sv
// Product term memory: one write port and one registered read port.
// Depends on spm_pkg.
`default_nettype none

module spm_prod_mem (
  input  wire                        clk,
  input  wire                        we,
  input  wire [spm_pkg::PADDR_W-1:0] waddr,
  input  spm_pkg::prod_word_t        wdata,
  input  wire [spm_pkg::PADDR_W-1:0] raddr,
  output spm_pkg::prod_word_t        rdata
);
  import spm_pkg::*;

  prod_word_t mem [PROD_DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule : spm_prod_mem

`default_nettype wire

FILE: test/spm_product_checker.sv
// Checker for the sparse polynomial multiplier: watches the input and result
// channels, predicts the merged product terms and compares them in order.
// Depends on spm_pkg for widths, store sizes and the item kinds.
module spm_product_checker (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  input  wire                                in_ready,
  input  wire [1:0]                          in_kind,
  input  wire signed [spm_pkg::COEF_W-1:0]   in_term_coef,
  input  wire [spm_pkg::EXP_W-1:0]           in_term_exp,
  input  wire                                out_valid,
  input  wire                                out_ready,
  input  wire signed [spm_pkg::PCOEF_W-1:0]  out_prod_coef,
  input  wire [spm_pkg::PEXP_W-1:0]          out_prod_exp,
  input  wire                                out_last_term,
  output int                                 fails,
  output int                                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import spm_pkg::*;

  typedef struct packed {
    logic signed [PCOEF_W-1:0] coef;
    logic [PEXP_W-1:0]         pexp;
    logic                      last;
  } result_term_t;

  // Product terms still owed by the block, oldest first.
  result_term_t expected_terms[$];

  // Local copy of the two term stores.
  logic signed [COEF_W-1:0] first_coef [MAX_TERMS_FIRST];
  logic [EXP_W-1:0]         first_exp [MAX_TERMS_FIRST];
  int                       first_used;
  logic signed [COEF_W-1:0] second_coef [MAX_TERMS_SECOND];
  logic [EXP_W-1:0]         second_exp [MAX_TERMS_SECOND];
  int                       second_used;

  initial begin
    fails = 0;
    pending = 0;
    first_used = 0;
    second_used = 0;
  end

  // One line per mismatch; printing stops after 200 lines.
  task automatic flag_mismatch(string what);
    if (fails < 200) begin
      $display("%0t ns mismatch: %s", $time, what);
    end
    fails++;
  endtask

  // Apply one accepted item to the stores; a multiply queues its merged terms.
  task automatic multiply_terms(kind_t kind, logic signed [COEF_W-1:0] coef,
                                logic [EXP_W-1:0] texp);
    logic signed [PCOEF_W-1:0] sum_coef [PROD_DEPTH];
    logic [PEXP_W-1:0]         sum_exp [PROD_DEPTH];
    logic signed [PCOEF_W-1:0] a;
    logic signed [PCOEF_W-1:0] b;
    logic [PEXP_W-1:0]         e;
    result_term_t              r;
    int                        n;
    int                        i;
    int                        j;
    int                        k;
    n = 0;
    case (kind)
      KIND_FIRST: begin
        if (first_used < MAX_TERMS_FIRST) begin
          first_coef[first_used] = coef;
          first_exp[first_used] = texp;
          first_used++;
        end
      end
      KIND_SECOND: begin
        if (second_used < MAX_TERMS_SECOND) begin
          second_coef[second_used] = coef;
          second_exp[second_used] = texp;
          second_used++;
        end
      end
      KIND_MUL: begin
        // First polynomial outer, second inner; merge on equal exponent.
        for (i = 0; i < first_used; i++) begin
          for (j = 0; j < second_used; j++) begin
            a = first_coef[i];
            b = second_coef[j];
            e = PEXP_W'(first_exp[i]) + PEXP_W'(second_exp[j]);
            k = 0;
            while (k < n && sum_exp[k] != e) begin
              k++;
            end
            if (k < n) begin
              sum_coef[k] = sum_coef[k] + a * b;
            end else begin
              sum_coef[n] = a * b;
              sum_exp[n] = e;
              n++;
            end
          end
        end
        for (k = 0; k < n; k++) begin
          r.coef = sum_coef[k];
          r.pexp = sum_exp[k];
          r.last = (k == n - 1);
          expected_terms.push_back(r);
        end
        first_used = 0;
        second_used = 0;
      end
      default: begin
      end
    endcase
  endtask

  // Compare one accepted result with the oldest expected term.
  task automatic check_result();
    result_term_t want;
    if (expected_terms.size() == 0) begin
      flag_mismatch($sformatf("unexpected result coef %0d exp %0d last %0b",
                              out_prod_coef, out_prod_exp, out_last_term));
    end else begin
      want = expected_terms.pop_front();
      if (out_prod_coef !== want.coef || out_prod_exp !== want.pexp ||
          out_last_term !== want.last) begin
        flag_mismatch($sformatf("got coef %0d exp %0d last %0b, want coef %0d exp %0d last %0b",
                                out_prod_coef, out_prod_exp, out_last_term,
                                $signed(want.coef), want.pexp, want.last));
      end
    end
  endtask

  // Sample both channels at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        check_result();
      end
      if (in_valid && in_ready) begin
        multiply_terms(kind_t'(in_kind), in_term_coef, in_term_exp);
      end
      pending = expected_terms.size();
    end
  end

endmodule

FILE: test/tb_sparse_polynomial_multiply.sv
// Testbench top for the sparse polynomial multiplier: clock, reset, term and
// multiply items, result back-pressure, watchdog and the final verdict.
// Depends on spm_pkg, sparse_polynomial_multiply and spm_product_checker.
module tb_sparse_polynomial_multiply;
  timeunit 1ns;
  timeprecision 1ps;
  import spm_pkg::*;

  localparam int QUIET_LIMIT = 50000;
  localparam int ITEM_TARGET = 350;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [1:0]                in_kind = KIND_IGNORE;
  logic signed [COEF_W-1:0]  in_term_coef = '0;
  logic [EXP_W-1:0]          in_term_exp = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [PCOEF_W-1:0] out_prod_coef;
  logic [PEXP_W-1:0]         out_prod_exp;
  logic                      out_last_term;
  int                        fails;
  int                        pending;
  int                        items_sent = 0;
  int                        quiet_cycles = 0;
  logic                      steady = 1'b0;

  sparse_polynomial_multiply DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_term_coef  (in_term_coef),
    .in_term_exp   (in_term_exp),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_prod_coef (out_prod_coef),
    .out_prod_exp  (out_prod_exp),
    .out_last_term (out_last_term)
  );

  spm_product_checker product_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_term_coef  (in_term_coef),
    .in_term_exp   (in_term_exp),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_prod_coef (out_prod_coef),
    .out_prod_exp  (out_prod_exp),
    .out_last_term (out_last_term),
    .fails         (fails),
    .pending       (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result back-pressure: out_ready drops with a chance of 16 in a hundred, never while steady.
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 16);
  end

  // Watchdog: ends the run after too long with no item moving on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Present one item after a random gap and hold it until it is taken.
  task automatic send_item(kind_t kind, logic signed [COEF_W-1:0] coef,
                           logic [EXP_W-1:0] texp);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_term_coef <= coef;
    in_term_exp <= texp;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    if (kind != KIND_IGNORE) begin
      items_sent++;
    end
  endtask

  // Coefficient styles: full range, corner values, tiny values, all minimum.
  function automatic logic signed [COEF_W-1:0] pick_coef(int mode);
    case (mode)
      0: return COEF_W'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return -16'sd1;
          3: return 16'sd0;
          default: return 16'sd1;
        endcase
      end
      2: return COEF_W'($signed($urandom_range(0, 4)) - 2);
      default: return 16'sh8000;
    endcase
  endfunction

  // Exponent styles: full range, a few values so terms merge, the two ends.
  function automatic logic [EXP_W-1:0] pick_exp(int mode);
    case (mode)
      0: return EXP_W'($urandom_range(0, 255));
      1: return EXP_W'($urandom_range(0, 3));
      default: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
    endcase
  endfunction

  // Load two polynomials in mixed order with some ignored items, then multiply.
  task automatic run_sequence();
    int    first_left;
    int    second_left;
    int    shape;
    int    coef_mode;
    int    exp_mode;
    kind_t kind;
    shape = $urandom_range(0, 99);
    if (shape < 8) begin
      // Large sets, often past the store size.
      first_left = $urandom_range(6, 10);
      second_left = $urandom_range(6, 10);
    end else if (shape < 14) begin
      // One side (or both) left empty.
      first_left = (shape < 11) ? $urandom_range(0, 3) : 0;
      second_left = (shape < 11) ? 0 : $urandom_range(0, 3);
    end else begin
      first_left = $urandom_range(1, 4);
      second_left = $urandom_range(1, 4);
    end
    coef_mode = $urandom_range(0, 3);
    exp_mode = $urandom_range(0, 2);
    while (first_left + second_left > 0) begin
      if ($urandom_range(0, 99) < 8) begin
        send_item(KIND_IGNORE, COEF_W'($urandom), EXP_W'($urandom));
      end
      if (second_left == 0 || (first_left > 0 && $urandom_range(0, 1) == 1)) begin
        kind = KIND_FIRST;
        first_left--;
      end else begin
        kind = KIND_SECOND;
        second_left--;
      end
      send_item(kind, pick_coef(coef_mode), pick_exp(exp_mode));
    end
    send_item(KIND_MUL, COEF_W'($urandom), EXP_W'($urandom));
  endtask

  initial begin
    int seq_count;
    int k;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Multiply with both stores empty, then an ignored kind.
    send_item(KIND_MUL, 16'sh1234, 8'h56);
    send_item(KIND_IGNORE, 16'sh5a5a, 8'ha5);

    // Extreme coefficients and exponents on both sides.
    send_item(KIND_FIRST, 16'sh8000, 8'd255);
    send_item(KIND_FIRST, 16'sh7fff, 8'd0);
    send_item(KIND_SECOND, 16'sh8000, 8'd255);
    send_item(KIND_SECOND, 16'sh7fff, 8'd0);
    send_item(KIND_MUL, 16'sh7fff, 8'hff);

    // Products that cancel to a zero sum, which must still come out.
    send_item(KIND_FIRST, 16'sd1, 8'd0);
    send_item(KIND_FIRST, 16'sd1, 8'd1);
    send_item(KIND_SECOND, 16'sd1, 8'd1);
    send_item(KIND_SECOND, -16'sd1, 8'd2);
    send_item(KIND_MUL, 16'sd0, 8'd0);

    // Nine terms into the first store: the last one is dropped.
    for (k = 0; k < 9; k++) begin
      send_item(KIND_FIRST, COEF_W'(100 * k - 450), EXP_W'(30 * k));
    end
    send_item(KIND_SECOND, -16'sd3, 8'd7);
    send_item(KIND_MUL, 16'sh0000, 8'h00);

    // Only the second store loaded.
    send_item(KIND_SECOND, 16'sd5, 8'd9);
    send_item(KIND_MUL, -16'sd1, 8'hff);

    // Random polynomials, with a stretch free of gaps and stalls.
    seq_count = 0;
    while (items_sent < ITEM_TARGET) begin
      steady = (seq_count >= 20 && seq_count < 30);
      run_sequence();
      seq_count++;
    end
    steady = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain the remaining results, then allow for a late stray one.
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (300) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
src/spm_pkg.sv
src/spm_term_store.sv
src/spm_prod_mem.sv
src/sparse_polynomial_multiply.sv
test/spm_product_checker.sv
test/tb_sparse_polynomial_multiply.sv
